@@ rtl/mrff_pkg.sv @@
// Package: shared constants and types for the 802.15.4 receive frame filter.
package mrff_pkg;

   localparam int MaxFrameDefault = 127;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FCS       = 3'd1,
      ST_SHORT     = 3'd2,
      ST_SECURITY  = 3'd3,
      ST_ACK_ADDR  = 3'd4,
      ST_TRUNCATED = 3'd5,
      ST_BAD_TYPE  = 3'd6,
      ST_TOO_LONG  = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      DLV_HOST      = 2'd0,
      DLV_BROADCAST = 2'd1,
      DLV_OTHER     = 2'd2
   } delivery_type;

   localparam logic [1:0] CSR_PAN   = 2'd0;
   localparam logic [1:0] CSR_SHORT = 2'd1;
   localparam logic [1:0] CSR_LONG  = 2'd2;
   localparam logic [1:0] CSR_SKIP  = 2'd3;

   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_SHORT = 2'd2;

   localparam logic [2:0] TYPE_ACK = 3'd2;

   // Frame summary handed from the front part to the back part.
   typedef struct packed {
      logic [7:0]  len;
      logic        crc_zero;
      logic [15:0] fc;
      logic [7:0]  seq;
      logic [15:0] dst_pan;
      logic [63:0] dst_addr;
      logic [15:0] src_pan;
      logic [63:0] src_addr;
   } frame_type_s_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  frame_type;
      logic [7:0]  seq_num;
      logic        ack_request;
      logic [1:0]  dst_mode;
      logic [15:0] dst_pan;
      logic [63:0] dst_address;
      logic [1:0]  src_mode;
      logic [15:0] src_pan;
      logic [63:0] src_address;
      logic [1:0]  delivery;
      logic [6:0]  payload_len;
   } report_type;

   function automatic logic [15:0] crc_next(input logic [15:0] c_in, input logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ rtl/mrff_if.sv @@
// Interfaces: request and result channels with valid/ready handshake.
interface mrff_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_end;
   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mrff_rsp_if;
   logic                valid;
   logic                ready;
   mrff_pkg::report_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/mrff_front.sv @@
// Front part: per-byte CRC, byte count and header field capture.
module mrff_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [7:0]                 in_byte,
   input  logic                       in_end,
   output logic                       out_valid,
   input  logic                       out_ready,
   output mrff_pkg::frame_type_s_type out_frame
);
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [15:0] fc_ff, fc_in;
   logic [7:0]  seq_ff, seq_in;
   logic [15:0] dpan_ff, dpan_in, span_ff, span_in;
   logic [63:0] daddr_ff, daddr_in, saddr_ff, saddr_in;
   logic [7:0]  dpan_off, daddr_off, span_off, saddr_off;
   logic [3:0]  dlen, slen;
   logic [1:0]  dm, sm;
   logic        intra, take;
   logic [7:0]  rel;

   assign in_ready = out_ready;
   assign take = in_valid & in_ready;
   assign dm = fc_ff[11:10];
   assign sm = fc_ff[15:14];
   assign intra = fc_ff[6];
   assign dlen = (dm == mrff_pkg::MODE_SHORT) ? 4'd2 : 4'd8;
   assign slen = (sm == mrff_pkg::MODE_SHORT) ? 4'd2 : 4'd8;

   always_comb begin
      dpan_off  = 8'd3;
      daddr_off = 8'd5;
      span_off  = (dm != mrff_pkg::MODE_NONE) ? 8'd5 + {4'd0, dlen} : 8'd3;
      saddr_off = span_off + (intra ? 8'd0 : 8'd2);
   end

   // Next values include the current byte; the clear at frame end is in the register block.
   always_comb begin
      crc_in = crc_ff; cnt_in = cnt_ff; fc_in = fc_ff; seq_in = seq_ff;
      dpan_in = dpan_ff; daddr_in = daddr_ff; span_in = span_ff; saddr_in = saddr_ff;
      rel = 8'd0;
      if (take) begin
         crc_in = mrff_pkg::crc_next(crc_ff, in_byte);
         cnt_in = (cnt_ff == 8'hff) ? cnt_ff : cnt_ff + 8'd1;
         if (cnt_ff == 8'd0) fc_in[7:0] = in_byte;
         else if (cnt_ff == 8'd1) fc_in[15:8] = in_byte;
         else if (cnt_ff == 8'd2) seq_in = in_byte;
         else begin
            if (dm != mrff_pkg::MODE_NONE) begin
               rel = cnt_ff - dpan_off;
               if (cnt_ff >= dpan_off && rel < 8'd2) dpan_in[rel[0]*8 +: 8] = in_byte;
               rel = cnt_ff - daddr_off;
               if (cnt_ff >= daddr_off && rel < {4'd0, dlen})
                  daddr_in[rel[2:0]*8 +: 8] = in_byte;
            end
            if (sm != mrff_pkg::MODE_NONE) begin
               rel = cnt_ff - span_off;
               if (!intra && cnt_ff >= span_off && rel < 8'd2)
                  span_in[rel[0]*8 +: 8] = in_byte;
               rel = cnt_ff - saddr_off;
               if (cnt_ff >= saddr_off && rel < {4'd0, slen})
                  saddr_in[rel[2:0]*8 +: 8] = in_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (take && in_end)) begin
         crc_ff <= '0; cnt_ff <= '0; fc_ff <= '0; seq_ff <= '0;
         dpan_ff <= '0; daddr_ff <= '0; span_ff <= '0; saddr_ff <= '0;
      end else begin
         crc_ff <= crc_in; cnt_ff <= cnt_in; fc_ff <= fc_in; seq_ff <= seq_in;
         dpan_ff <= dpan_in; daddr_ff <= daddr_in; span_ff <= span_in; saddr_ff <= saddr_in;
      end
   end

   // Summary of the frame as it stands after the final byte.
   always_comb begin
      out_valid = take & in_end;
      out_frame.len      = cnt_ff + 8'd1;
      out_frame.crc_zero = (crc_in == 16'd0);
      out_frame.fc       = fc_in;
      out_frame.seq      = seq_in;
      out_frame.dst_pan  = dpan_in;
      out_frame.dst_addr = daddr_in;
      out_frame.src_pan  = span_in;
      out_frame.src_addr = saddr_in;
   end
endmodule

@@ rtl/mrff_back.sv @@
// Back part: frame summary queue, checks, classification and result register.
module mrff_back #(
   parameter int MaxFrame = mrff_pkg::MaxFrameDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  mrff_pkg::frame_type_s_type in_frame,
   input  logic [15:0]                own_pan,
   input  logic [15:0]                own_short,
   input  logic [63:0]                own_long,
   input  logic                       skip_fcs,
   output logic                       out_valid,
   input  logic                       out_ready,
   output mrff_pkg::report_type       out_report
);
   localparam logic [8:0] MaxLen = 9'(MaxFrame);

   // Two-entry queue between front and evaluation.
   mrff_pkg::frame_type_s_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;
   mrff_pkg::frame_type_s_type f;
   mrff_pkg::report_type rep;
   logic       rv_ff, rv_in;
   mrff_pkg::report_type r_ff;

   logic [8:0] len, m, hlen;
   logic [2:0] ty;
   logic [1:0] dm, sm, dlv;
   logic       intra, hdr, addrs;
   logic [15:0] dpan, span;
   mrff_pkg::status_type st;

   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid & in_ready;
   assign pop  = (cnt_ff != 2'd0) & (!rv_ff | out_ready);
   assign f = q_ff[rd_ff];

   always_comb begin
      len = {1'b0, f.len};
      ty = f.fc[2:0]; dm = f.fc[11:10]; sm = f.fc[15:14]; intra = f.fc[6];
      hlen = 9'd3;
      if (dm != mrff_pkg::MODE_NONE) hlen = hlen + ((dm == mrff_pkg::MODE_SHORT) ? 9'd4 : 9'd10);
      if (sm != mrff_pkg::MODE_NONE)
         hlen = hlen + (intra ? 9'd0 : 9'd2) + ((sm == mrff_pkg::MODE_SHORT) ? 9'd2 : 9'd8);
      m = len; st = mrff_pkg::ST_OK; hdr = 1'b0; addrs = 1'b0;
      // byte count saturates at 255, so a length that wraps to 0 means too long
      if (f.len == 8'd0 || len > MaxLen) st = mrff_pkg::ST_TOO_LONG;
      else if (!skip_fcs && (len < 9'd2 || !f.crc_zero)) st = mrff_pkg::ST_FCS;
      if (st == mrff_pkg::ST_OK && !skip_fcs) m = len - 9'd2;
      if (st == mrff_pkg::ST_OK && m < 9'd3) st = mrff_pkg::ST_SHORT;
      if (st == mrff_pkg::ST_OK) begin
         hdr = 1'b1;
         if (f.fc[3]) st = mrff_pkg::ST_SECURITY;
         else if (ty == mrff_pkg::TYPE_ACK && (dm != 2'd0 || sm != 2'd0))
            st = mrff_pkg::ST_ACK_ADDR;
         else if (hlen > m) st = mrff_pkg::ST_TRUNCATED;
         else begin
            addrs = 1'b1;
            if (ty > 3'd3) st = mrff_pkg::ST_BAD_TYPE;
         end
      end
      dpan = (dm != 2'd0) ? f.dst_pan : 16'd0;
      span = intra ? dpan : ((sm != 2'd0) ? f.src_pan : 16'd0);
      if (dm == 2'd0) dlv = (sm != 2'd0) ? mrff_pkg::DLV_OTHER : mrff_pkg::DLV_HOST;
      else if (dm == 2'd1) dlv = mrff_pkg::DLV_OTHER;
      else if (dpan != own_pan && dpan != 16'hffff) dlv = mrff_pkg::DLV_OTHER;
      else if (dm == mrff_pkg::MODE_SHORT)
         dlv = (f.dst_addr[15:0] == own_short) ? mrff_pkg::DLV_HOST :
               (f.dst_addr[15:0] == 16'hffff) ? mrff_pkg::DLV_BROADCAST : mrff_pkg::DLV_OTHER;
      else
         dlv = (f.dst_addr == own_long) ? mrff_pkg::DLV_HOST :
               (&f.dst_addr) ? mrff_pkg::DLV_BROADCAST : mrff_pkg::DLV_OTHER;
      rep = '0;
      rep.status = st;
      if (hdr) begin
         rep.frame_type = ty; rep.seq_num = f.seq; rep.ack_request = f.fc[5];
         rep.dst_mode = dm; rep.src_mode = sm;
      end
      if (addrs) begin
         rep.dst_pan = dpan;
         rep.dst_address = (dm != 2'd0) ? f.dst_addr : 64'd0;
         rep.src_pan = span;
         rep.src_address = (sm != 2'd0) ? f.src_addr : 64'd0;
         rep.delivery = dlv;
         if (st == mrff_pkg::ST_OK)
            rep.payload_len = ((m - hlen) > 9'd127) ? 7'd127 : 7'(m - hlen);
      end
   end

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in = rd_ff ^ pop;
      wr_in = wr_ff ^ push;
      rv_in = pop ? 1'b1 : (out_ready ? 1'b0 : rv_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; rd_ff <= 1'b0; wr_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; rd_ff <= rd_in; wr_ff <= wr_in; rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= in_frame;
      if (pop) r_ff <= rep;
   end

   assign out_valid = rv_ff;
   assign out_report = r_ff;

   a_cnt_max: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overflow");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> rd_ff == wr_ff)
      else $error("queue pointers disagree with count");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !out_ready) |=> (rv_ff && $stable(r_ff)))
      else $error("result changed while stalled");
endmodule

@@ rtl/mac_receive_frame_filter_top.sv @@
// Top level: 802.15.4 receive frame filter with configuration registers.
// One frame byte is accepted every cycle; the front part runs CRC and header
// capture per byte, and at the final byte hands a frame summary through a
// two-entry queue to the back part, which checks and classifies it and
// registers the report as the summary leaves the queue. Bytes stall only
// while the queue is full, i.e. when result-side stalls have backed up two
// finished frames.
module mac_receive_frame_filter_top #(
   parameter int MaxFrame = mrff_pkg::MaxFrameDefault
) (
   input  logic        clock,
   input  logic        reset,
   mrff_req_if.sink    req,
   mrff_rsp_if.source  rsp,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);
   logic [15:0] pan_ff, short_ff;
   logic [63:0] long_ff;
   logic        skip_ff;
   logic        f_valid, f_ready;
   mrff_pkg::frame_type_s_type f_frame;

   always_ff @(posedge clock) begin
      if (reset) begin
         pan_ff <= 16'hffff; short_ff <= 16'hffff; long_ff <= '0; skip_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mrff_pkg::CSR_PAN:   pan_ff <= csr_write_data[15:0];
            mrff_pkg::CSR_SHORT: short_ff <= csr_write_data[15:0];
            mrff_pkg::CSR_LONG:  long_ff <= csr_write_data;
            mrff_pkg::CSR_SKIP:  skip_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   mrff_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready),
      .in_byte(req.rx_byte), .in_end(req.frame_end),
      .out_valid(f_valid), .out_ready(f_ready), .out_frame(f_frame)
   );

   mrff_back #(.MaxFrame(MaxFrame)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_frame(f_frame),
      .own_pan(pan_ff), .own_short(short_ff), .own_long(long_ff), .skip_fcs(skip_ff),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_report(rsp.data)
   );
endmodule

@@ test/tb_mrff_checker.sv @@
// Checker: predicts frame filter reports from accepted requests and compares them.
module tb_mrff_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   input  logic                 req_frame_end,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  mrff_pkg::report_type rsp_data,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [63:0]          csr_write_data,
   output int                   fail_count,
   output int                   pending_reports,
   output int                   report_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [15:0] own_pan, own_short;
   logic [63:0] own_long;
   logic        skip_fcs;

   logic [15:0] crc;
   logic [7:0]  count;
   logic [15:0] fc;
   logic [7:0]  seq;
   logic [15:0] dpan_h, span_h;
   logic [63:0] daddr_h, saddr_h;

   mrff_pkg::report_type expected_reports[$];

   // Header offsets derived from the frame control field.
   function automatic void header_layout(input logic [15:0] f, output int dpan_off,
                                         output int daddr_off, output int dlen,
                                         output int span_off, output int splen,
                                         output int saddr_off, output int slen,
                                         output int hlen);
      int o;
      o = 3;
      dpan_off = 0; daddr_off = 0; dlen = 0; span_off = 0; splen = 0;
      saddr_off = 0; slen = 0;
      if (f[11:10] != mrff_pkg::MODE_NONE) begin
         dpan_off = o; o += 2;
         daddr_off = o; dlen = (f[11:10] == mrff_pkg::MODE_SHORT) ? 2 : 8; o += dlen;
      end
      if (f[15:14] != mrff_pkg::MODE_NONE) begin
         if (!f[6]) begin
            span_off = o; splen = 2; o += 2;
         end
         saddr_off = o; slen = (f[15:14] == mrff_pkg::MODE_SHORT) ? 2 : 8; o += slen;
      end
      hlen = o;
   endfunction

   function automatic mrff_pkg::report_type frame_report(input int len);
      mrff_pkg::report_type r;
      int dpo, dao, dl, spo, spl, sao, sl, hl, m, pay;
      mrff_pkg::status_type st;
      logic hdr, addrs;
      logic [1:0] dm, sm;
      logic [15:0] dpan, span;
      mrff_pkg::delivery_type dv;
      header_layout(fc, dpo, dao, dl, spo, spl, sao, sl, hl);
      r = '0;
      st = mrff_pkg::ST_OK; hdr = 0; addrs = 0; m = len; pay = 0;
      dm = fc[11:10]; sm = fc[15:14];
      if (len > mrff_pkg::MaxFrameDefault) st = mrff_pkg::ST_TOO_LONG;
      else if (!skip_fcs && (len < 2 || crc != 0)) st = mrff_pkg::ST_FCS;
      if (st == mrff_pkg::ST_OK && !skip_fcs) m = len - 2;
      if (st == mrff_pkg::ST_OK && m < 3) st = mrff_pkg::ST_SHORT;
      if (st == mrff_pkg::ST_OK) begin
         hdr = 1;
         if (fc[3]) st = mrff_pkg::ST_SECURITY;
         else if (fc[2:0] == mrff_pkg::TYPE_ACK && (dm != 0 || sm != 0))
            st = mrff_pkg::ST_ACK_ADDR;
         else if (hl > m) st = mrff_pkg::ST_TRUNCATED;
         else begin
            addrs = 1;
            if (fc[2:0] > 3) st = mrff_pkg::ST_BAD_TYPE;
            else pay = (m - hl > 127) ? 127 : m - hl;
         end
      end
      dpan = (dm != 0) ? dpan_h : 16'h0;
      span = fc[6] ? dpan : ((sm != 0) ? span_h : 16'h0);
      if (dm == 0) dv = (sm != 0) ? mrff_pkg::DLV_OTHER : mrff_pkg::DLV_HOST;
      else if (dm == 1) dv = mrff_pkg::DLV_OTHER;
      else if (dpan != own_pan && dpan != 16'hffff) dv = mrff_pkg::DLV_OTHER;
      else if (dm == mrff_pkg::MODE_SHORT)
         dv = (daddr_h[15:0] == own_short) ? mrff_pkg::DLV_HOST
            : (daddr_h[15:0] == 16'hffff) ? mrff_pkg::DLV_BROADCAST : mrff_pkg::DLV_OTHER;
      else
         dv = (daddr_h == own_long) ? mrff_pkg::DLV_HOST
            : (daddr_h == '1) ? mrff_pkg::DLV_BROADCAST : mrff_pkg::DLV_OTHER;
      r.status = st;
      if (hdr) begin
         r.frame_type = fc[2:0]; r.seq_num = seq; r.ack_request = fc[5];
         r.dst_mode = dm; r.src_mode = sm;
      end
      if (addrs) begin
         r.dst_pan = dpan;
         r.dst_address = (dm != 0) ? daddr_h : 64'h0;
         r.src_pan = span;
         r.src_address = (sm != 0) ? saddr_h : 64'h0;
         r.delivery = dv;
         r.payload_len = pay[6:0];
      end
      return r;
   endfunction

   task automatic take_byte(input logic [7:0] b, input logic last);
      int p, dpo, dao, dl, spo, spl, sao, sl, hl;
      p = count;
      crc = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) crc = crc[0] ? ((crc >> 1) ^ 16'h8408) : (crc >> 1);
      if (p == 0) fc[7:0] = b;
      else if (p == 1) fc[15:8] = b;
      else if (p == 2) seq = b;
      else begin
         header_layout(fc, dpo, dao, dl, spo, spl, sao, sl, hl);
         if (dl != 0 && p >= dpo && p < dpo + 2) dpan_h[8*(p-dpo) +: 8] = b;
         if (dl != 0 && p >= dao && p < dao + dl) daddr_h[8*(p-dao) +: 8] = b;
         if (spl != 0 && p >= spo && p < spo + 2) span_h[8*(p-spo) +: 8] = b;
         if (sl != 0 && p >= sao && p < sao + sl) saddr_h[8*(p-sao) +: 8] = b;
      end
      if (count < 255) count++;
      if (last) begin
         expected_reports.push_back(frame_report(p + 1));
         crc = 0; count = 0; fc = 0; seq = 0;
         dpan_h = 0; span_h = 0; daddr_h = 0; saddr_h = 0;
      end
   endtask

   always @(posedge clock) begin
      mrff_pkg::report_type want;
      if (reset) begin
         own_pan <= 16'hffff; own_short <= 16'hffff; own_long <= 0; skip_fcs <= 0;
         crc = 0; count = 0; fc = 0; seq = 0;
         dpan_h = 0; span_h = 0; daddr_h = 0; saddr_h = 0;
         fail_count = 0; report_count = 0;
      end else begin
         if (req_valid && req_ready) take_byte(req_rx_byte, req_frame_end);
         if (rsp_valid && rsp_ready) begin
            report_count++;
            if (expected_reports.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("ERROR: unexpected report %p", rsp_data);
            end else begin
               want = expected_reports.pop_front();
               if (rsp_data !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("ERROR: report mismatch\n  expected %p\n  actual   %p",
                              want, rsp_data);
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               mrff_pkg::CSR_PAN:   own_pan   <= csr_write_data[15:0];
               mrff_pkg::CSR_SHORT: own_short <= csr_write_data[15:0];
               mrff_pkg::CSR_LONG:  own_long  <= csr_write_data;
               mrff_pkg::CSR_SKIP:  skip_fcs  <= csr_write_data[0];
               default: ;
            endcase
         end
      end
      pending_reports = expected_reports.size();
   end
endmodule

@@ test/tb_top.sv @@
// Testbench top: clock, reset, configuration phases, frame stimulus and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock, reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [63:0] csr_write_data;
   int          fail_count, pending_reports, report_count;
   int          byte_total;

   mrff_req_if req ();
   mrff_rsp_if rsp ();

   mac_receive_frame_filter_top dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   tb_mrff_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_rx_byte(req.rx_byte),
      .req_frame_end(req.frame_end),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .fail_count(fail_count), .pending_reports(pending_reports),
      .report_count(report_count)
   );

   logic [15:0] own_pan, own_short;
   logic [63:0] own_long;
   logic        skip_fcs;
   logic [7:0]  frame_buf[$];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

   // Result side stalls at random, with calm stretches.
   initial begin
      int wait_cycles;
      rsp.ready = 0;
      @(posedge clock iff !reset);
      forever begin
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
         repeat (wait_cycles) @(posedge clock);
         rsp.ready <= 1;
         @(posedge clock iff rsp.valid);
         rsp.ready <= 0;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] val);
      csr_write_enable <= 1; csr_index <= idx; csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic configure(input logic [15:0] pan, input logic [15:0] sa,
                            input logic [63:0] la, input logic skip);
      req.valid <= 0;
      @(posedge clock);
      while (pending_reports != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      own_pan = pan; own_short = sa; own_long = la; skip_fcs = skip;
      csr_write(mrff_pkg::CSR_PAN, {48'h0, pan});
      csr_write(mrff_pkg::CSR_SHORT, {48'h0, sa});
      csr_write(mrff_pkg::CSR_LONG, la);
      csr_write(mrff_pkg::CSR_SKIP, {63'h0, skip});
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last, input bit busy);
      int gap;
      gap = busy ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1; req.rx_byte <= b; req.frame_end <= last;
      @(posedge clock iff req.ready);
      byte_total++;
   endtask

   // Sends frame_buf: kind 0 as is, 1 with a correct FCS, 2 with a corrupted
   // FCS, 3 cut by three bytes and then given a correct FCS.
   task automatic send_frame(input int fcs_kind);
      logic [15:0] c;
      bit busy;
      if (fcs_kind == 3) repeat (3) void'(frame_buf.pop_back());
      c = 0;
      foreach (frame_buf[i]) begin
         c = c ^ {8'h00, frame_buf[i]};
         for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
      end
      if (fcs_kind == 1 || fcs_kind == 3) begin
         frame_buf.push_back(c[7:0]); frame_buf.push_back(c[15:8]);
      end else if (fcs_kind == 2) begin
         frame_buf.push_back(c[7:0] ^ 8'h01); frame_buf.push_back(c[15:8]);
      end
      busy = ($urandom_range(0, 2) == 0);
      foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1, busy);
      frame_buf.delete();
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Builds a header with chosen type and modes; addresses often match own ones.
   task automatic build_frame(input logic [2:0] ftype, input logic [1:0] dm,
                              input logic [1:0] sm, input int pay, input int fcs_kind);
      logic [15:0] f, pan;
      logic [63:0] da;
      int sel;
      f = 16'($urandom());
      f[2:0] = ftype; f[11:10] = dm; f[15:14] = sm;
      if ($urandom_range(0, 3) != 0) f[3] = 0;
      frame_buf.push_back(f[7:0]); frame_buf.push_back(f[15:8]);
      frame_buf.push_back(8'($urandom()));
      sel = $urandom_range(0, 3);
      pan = (sel == 0) ? own_pan : (sel == 1) ? 16'hffff : 16'($urandom());
      sel = $urandom_range(0, 3);
      da = (sel == 0) ? (dm == mrff_pkg::MODE_SHORT ? {48'h0, own_short} : own_long)
         : (sel == 1) ? '1 : rand64();
      if (dm != mrff_pkg::MODE_NONE) begin
         for (int i = 0; i < 2; i++) frame_buf.push_back(pan[8*i +: 8]);
         for (int i = 0; i < (dm == mrff_pkg::MODE_SHORT ? 2 : 8); i++)
            frame_buf.push_back(da[8*i +: 8]);
      end
      if (sm != mrff_pkg::MODE_NONE) begin
         da = rand64();
         if (!f[6]) begin
            frame_buf.push_back(8'($urandom())); frame_buf.push_back(8'($urandom()));
         end
         for (int i = 0; i < (sm == mrff_pkg::MODE_SHORT ? 2 : 8); i++)
            frame_buf.push_back(da[8*i +: 8]);
      end
      for (int i = 0; i < pay; i++) frame_buf.push_back(8'($urandom()));
      send_frame((skip_fcs && fcs_kind != 3) ? 0 : fcs_kind);
   endtask

   task automatic random_frame();
      int kind, len;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         build_frame($urandom_range(0, 3) == 0 ? 3'($urandom()) : 3'($urandom_range(0, 3)),
                     2'($urandom()), 2'($urandom()),
                     $urandom_range(0, 3) == 0 ? $urandom_range(0, 100) : $urandom_range(0, 8),
                     $urandom_range(0, 7) == 0 ? 2 : 1);
      end else if (kind == 7) begin
         // truncated header: cut a well-formed frame short
         build_frame(3'($urandom_range(0, 3)), 2'd3, 2'd3, 0, 3);
      end else begin
         len = $urandom_range(1, 12);
         for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom()));
         send_frame($urandom_range(0, 1));
      end
   endtask

   initial begin
      int phase;
      reset = 1;
      byte_total = 0;
      req.valid = 0; req.rx_byte = 0; req.frame_end = 0;
      csr_write_enable = 0; csr_index = mrff_pkg::CSR_PAN; csr_write_data = 0;
      own_pan = 16'hffff; own_short = 16'hffff; own_long = 0; skip_fcs = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: all-ones registers, then specials
      configure(16'hffff, 16'hffff, 64'hffff_ffff_ffff_ffff, 0);
      build_frame(3'd1, 2'd2, 2'd2, 0, 1);   // short addresses, own unassigned
      build_frame(3'd1, 2'd3, 2'd3, 4, 1);   // long addresses
      build_frame(3'd1, 2'd1, 2'd1, 2, 1);   // reserved mode 1
      build_frame(3'd0, 2'd0, 2'd2, 1, 1);   // no destination
      build_frame(3'd0, 2'd0, 2'd0, 0, 1);   // bare header
      build_frame(3'd2, 2'd0, 2'd0, 0, 1);   // plain ack
      build_frame(3'd2, 2'd2, 2'd0, 0, 1);   // ack with addresses
      build_frame(3'd5, 2'd2, 2'd2, 3, 1);   // reserved type
      build_frame(3'd3, 2'd2, 2'd2, 3, 2);   // bad FCS
      frame_buf.push_back(8'hff); send_frame(0);                 // single byte
      frame_buf.push_back(8'h00); frame_buf.push_back(8'h00); send_frame(0);
      frame_buf.push_back(8'h41); send_frame(1);                 // short after FCS
      build_frame(3'd1, 2'd2, 2'd2, 120, 1); // too long
      for (int i = 0; i < 300; i++) frame_buf.push_back(8'($urandom()));
      send_frame(0);                                             // saturating count
      build_frame(3'd1, 2'd3, 2'd3, 0, 3);   // header truncated

      configure(16'h0000, 16'h0000, 64'h0, 1);
      build_frame(3'd1, 2'd2, 2'd2, 0, 0);
      build_frame(3'd1, 2'd3, 2'd2, 106, 0); // long payload near the frame limit
      build_frame(3'd0, 2'd0, 2'd0, 0, 0);

      for (phase = 0; phase < 6; phase++) begin
         configure($urandom_range(0, 1) ? 16'h1234 : 16'($urandom()), 16'($urandom()),
                   rand64(), phase[0]);
         while (byte_total < 750 + (phase + 1) * 65) random_frame();
      end

      req.valid <= 0;
      @(posedge clock);
      while (pending_reports != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Run covered %0d request bytes and %0d frame reports over 8 register settings.",
               byte_total, report_count);
      if (fail_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end
endmodule

@@ mac_receive_frame_filter_top.f @@
rtl/mrff_pkg.sv
rtl/mrff_if.sv
rtl/mrff_front.sv
rtl/mrff_back.sv
rtl/mac_receive_frame_filter_top.sv
test/tb_mrff_checker.sv
test/tb_top.sv
